### hdl/byte_stream_hash64_seeded_unit_defines.svh
// Assertion macros shared by the hash unit modules.
// A module that includes this file must have clk and rst_n in scope.
`ifndef BYTE_STREAM_HASH64_SEEDED_UNIT_DEFINES_SVH
`define BYTE_STREAM_HASH64_SEEDED_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BSH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bsh_pkg.sv
// Shared types, constants and helpers for the seeded 64-bit byte-stream hash.
// No dependencies; used by bsh_front, bsh_back and the top module of the hash unit.
`default_nettype none

package bsh_pkg;

    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

    // Width of the message_length port.
    localparam int MSG_LEN_W = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEED = 2'd1;

    // One classified word as it travels from the front end to the back end.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;   // clamped to 0..8
        logic        full;     // eight bytes: mixed as a whole word
        logic        start;    // opens a new message
        logic        last;     // closes the message and produces a result
    } item_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        return (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

endpackage

`default_nettype wire

### hdl/bsh_front.sv
// Front end of the hash unit: accepts input beats and classifies each word.
// Depends on bsh_pkg; feeds bsh_queue.
`default_nettype none

module bsh_front #(
    parameter int LEN_W = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [63:0]                   data_word,
    input  wire logic [3:0]                    valid_bytes,
    input  wire logic [bsh_pkg::MSG_LEN_W-1:0] message_length,
    input  wire logic                          first_word,
    input  wire logic                          last_word,
    input  wire logic                          q_full,
    output logic                               q_push,
    output bsh_pkg::item_t                     q_item,
    output logic [LEN_W-1:0]                   q_len
);

    logic in_msg_reg;
    logic in_msg_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // A word seen while no message is open starts one, first mark or not.
    always_comb
    begin
        q_item.word   = data_word;
        q_item.full   = valid_bytes[3];
        q_item.nbytes = valid_bytes[3] ? 4'd8 : valid_bytes;
        q_item.start  = first_word || !in_msg_reg;
        q_item.last   = last_word;
        q_len         = message_length[LEN_W-1:0];
        in_msg_next   = in_msg_reg;
        if (q_push)
        begin
            in_msg_next = !last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bsh_queue.sv
// Small register FIFO between the front and back ends of the hash unit.
// Generic width and depth; depends on the shared assertion macros.
`default_nettype none
`include "byte_stream_hash64_seeded_unit_defines.svh"

module bsh_queue #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `BSH_ASSERT_IMPL(a_no_overflow, push, !full || pop, "queue written while full")
    `BSH_ASSERT_IMPL(a_no_underflow, pop, not_empty, "queue read while empty")

endmodule

`default_nettype wire

### hdl/bsh_mul.sv
// Iterative 64 x 64 multiplier keeping the low 64 bits of the product.
// One 32 x 32 partial product per cycle; done pulses once the third one is added in. No dependencies.
`default_nettype none

module bsh_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             busy,
    output logic             done,
    output logic [63:0]      product
);

    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_HL = 2'd1;
    localparam logic [1:0] PH_LH = 2'd2;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp;

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

    always_comb
    begin
        case (phase_reg)
            PH_LL:
            begin
                mx = a_reg[31:0];
                my = b_reg[31:0];
            end
            PH_HL:
            begin
                mx = a_reg[63:32];
                my = b_reg[31:0];
            end
            PH_LH:
            begin
                mx = a_reg[31:0];
                my = b_reg[63:32];
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign pp = {32'd0, mx} * {32'd0, my};

    // The high-by-high product only reaches bits 64 and up, so it is skipped.
    always_comb
    begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (busy_reg)
        begin
            if (phase_reg == PH_LL)
            begin
                acc_next = pp;
            end
            else
            begin
                acc_next = acc_reg + {pp[31:0], 32'd0};
            end
            if (phase_reg == PH_LH)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                phase_next = PH_LL;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
        else if (go)
        begin
            busy_next  = 1'b1;
            phase_next = PH_LL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LL;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (go && !busy_reg)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

endmodule

`default_nettype wire

### hdl/bsh_back.sv
// Back end of the hash unit: sequences the mixing rounds and the finish for
// each queued word over one shared multiplier. Depends on bsh_pkg and bsh_mul.
`default_nettype none
`include "byte_stream_hash64_seeded_unit_defines.svh"

module bsh_back #(
    parameter int LEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire bsh_pkg::item_t   q_item,
    input  wire logic [LEN_W-1:0] q_len,
    output logic                  q_pop,
    input  wire logic [63:0]      first_seed,
    input  wire logic [63:0]      second_seed,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [63:0]           hash_value
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_W1   = 4'd2;
    localparam logic [3:0] S_W2   = 4'd3;
    localparam logic [3:0] S_W3   = 4'd4;
    localparam logic [3:0] S_B1   = 4'd5;
    localparam logic [3:0] S_B2   = 4'd6;
    localparam logic [3:0] S_F1   = 4'd7;
    localparam logic [3:0] S_F2   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    bsh_pkg::item_t   item_reg;
    bsh_pkg::item_t   item_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [63:0]      hash_reg;
    logic [63:0]      hash_next;
    logic [63:0]      k_reg;
    logic [63:0]      k_next;
    logic [63:0]      word_reg;
    logic [63:0]      word_next;
    logic [3:0]       rem_reg;
    logic [3:0]       rem_next;
    logic             pend_reg;
    logic             pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      out_reg;
    logic [63:0]      out_next;

    logic             mul_go;
    logic             mul_busy;
    logic             mul_done;
    logic [63:0]      mul_a;
    logic [63:0]      mul_b;
    logic [63:0]      mul_p;
    logic             mul_state;

    // Where to go once the length seed is in place.
    function automatic logic [3:0] body_state(input bsh_pkg::item_t it);
        logic [3:0] s;
        if (it.full)
        begin
            s = S_W1;
        end
        else if (it.nbytes != 4'd0)
        begin
            s = S_B1;
        end
        else if (it.last)
        begin
            s = S_F1;
        end
        else
        begin
            s = S_IDLE;
        end
        return s;
    endfunction

    function automatic logic [3:0] fin_state(input logic last);
        return last ? S_F1 : S_IDLE;
    endfunction

    always_comb
    begin
        case (state_reg)
            S_INIT:
            begin
                mul_a = 64'(len_reg);
                mul_b = bsh_pkg::PRIME3;
            end
            S_W1:
            begin
                mul_a = item_reg.word;
                mul_b = bsh_pkg::PRIME2;
            end
            S_W2:
            begin
                mul_a = bsh_pkg::rotl64(k_reg, 6'd31);
                mul_b = bsh_pkg::PRIME1;
            end
            S_W3:
            begin
                mul_a = bsh_pkg::rotl64(hash_reg, 6'd27);
                mul_b = bsh_pkg::PRIME1;
            end
            S_B1:
            begin
                mul_a = {56'd0, word_reg[7:0]};
                mul_b = bsh_pkg::PRIME5;
            end
            S_B2:
            begin
                mul_a = bsh_pkg::rotl64(hash_reg, 6'd11);
                mul_b = bsh_pkg::PRIME1;
            end
            S_F1:
            begin
                mul_a = hash_reg ^ (hash_reg >> 33);
                mul_b = bsh_pkg::PRIME2;
            end
            S_F2:
            begin
                mul_a = k_reg ^ (k_reg >> 29);
                mul_b = bsh_pkg::PRIME3;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_state = (state_reg != S_IDLE) && (state_reg != S_OUT);
    assign mul_go    = mul_state && !pend_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    bsh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        len_next       = len_reg;
        hash_next      = hash_reg;
        k_next         = k_reg;
        word_next      = word_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (mul_go)
        begin
            pend_next = 1'b1;
        end
        else if (mul_done)
        begin
            pend_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    len_next   = q_len;
                    word_next  = q_item.word;
                    rem_next   = q_item.nbytes;
                    state_next = q_item.start ? S_INIT : body_state(q_item);
                end
            end
            S_INIT:
            begin
                if (mul_done)
                begin
                    hash_next  = bsh_pkg::PRIME5 + mul_p;
                    state_next = body_state(item_reg);
                end
            end
            S_W1:
            begin
                if (mul_done)
                begin
                    k_next     = mul_p;
                    state_next = S_W2;
                end
            end
            S_W2:
            begin
                if (mul_done)
                begin
                    hash_next  = hash_reg ^ mul_p;
                    state_next = S_W3;
                end
            end
            S_W3:
            begin
                if (mul_done)
                begin
                    hash_next  = mul_p + bsh_pkg::PRIME4;
                    state_next = fin_state(item_reg.last);
                end
            end
            S_B1:
            begin
                if (mul_done)
                begin
                    hash_next  = hash_reg ^ mul_p;
                    state_next = S_B2;
                end
            end
            S_B2:
            begin
                if (mul_done)
                begin
                    hash_next = mul_p;
                    word_next = word_reg >> 8;
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == 4'd1)
                    begin
                        state_next = fin_state(item_reg.last);
                    end
                    else
                    begin
                        state_next = S_B1;
                    end
                end
            end
            S_F1:
            begin
                if (mul_done)
                begin
                    k_next     = mul_p;
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                if (mul_done)
                begin
                    k_next     = mul_p;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Waits here only while the previous result is still unread.
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = k_reg ^ (k_reg >> 32) ^ first_seed ^ second_seed;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        len_reg  <= len_next;
        k_reg    <= k_next;
        word_reg <= word_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

    `BSH_ASSERT_IMPL(a_done_pending, mul_done, pend_reg, "multiplier result with no request")
    `BSH_ASSERT_IMPL(a_go_free, mul_go, !mul_busy, "multiplier started while busy")
    `BSH_ASSERT_IMPL(a_pop_quiet, q_pop, !pend_reg && !mul_busy, "word taken mid-operation")
    `BSH_ASSERT_NEXT(a_done_clears, mul_done, !pend_reg, "request left open after result")

endmodule

`default_nettype wire

### hdl/byte_stream_hash64_seeded_unit.sv
// Seeded 64-bit byte-stream hash unit: front end, word queue, back end and seed registers.
// Depends on bsh_pkg, bsh_front, bsh_queue, bsh_back (with bsh_mul) and the macro header.
//
// Usage:
// - Input channel (in_valid/in_ready): one beat per 64-bit little-endian message word,
//   with valid_bytes, message_length (read on the first word), first_word and last_word.
//   An empty message is a single beat with zero valid bytes and both marks set.
// - Output channel (out_valid/out_ready): one beat carrying hash_value per last word.
// - Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
//   first_seed, 1 writes second_seed; other indexes are ignored. Write only when idle.
// - The back end takes each word off the queue, then runs the 64-bit multiplications
//   it needs: one for a message start, three for a full word or two per tail byte, and
//   two for the finish on a last word. The shared multiplier builds each product from
//   three 32 x 32 partial products; the back end waits for each product before it
//   starts the next. A last word ends in an output state that loads the output register.
// - Beats queue up to QUEUE_DEPTH ahead; the back end works on one word at a time.
// - Reset clears the seeds, the running hash and the queue; no message is open.
// - A stalled receiver holds the result in the output register; the back end stops
//   only when a second result is ready, and input is taken until the queue fills.
`default_nettype none

module byte_stream_hash64_seeded_unit #(
    parameter int LENGTH_BITS = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [63:0]                   data_word,
    input  wire logic [3:0]                    valid_bytes,
    input  wire logic [bsh_pkg::MSG_LEN_W-1:0] message_length,
    input  wire logic                          first_word,
    input  wire logic                          last_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [63:0]                        hash_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data
);

    // Length bits that can affect the hash.
    localparam int LEN_W   = (LENGTH_BITS < bsh_pkg::MSG_LEN_W) ? LENGTH_BITS
                                                                : bsh_pkg::MSG_LEN_W;
    localparam int ITEM_W  = $bits(bsh_pkg::item_t);
    localparam int ENTRY_W = LEN_W + ITEM_W;

    logic [63:0]        first_seed_reg;
    logic [63:0]        first_seed_next;
    logic [63:0]        second_seed_reg;
    logic [63:0]        second_seed_next;

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_not_empty;
    bsh_pkg::item_t     f_item;
    logic [LEN_W-1:0]   f_len;
    logic [ENTRY_W-1:0] q_rdata;
    bsh_pkg::item_t     b_item;
    logic [LEN_W-1:0]   b_len;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        first_seed_next  = first_seed_reg;
        second_seed_next = second_seed_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bsh_pkg::REG_FIRST_SEED:  first_seed_next  = cfg_data;
                bsh_pkg::REG_SECOND_SEED: second_seed_next = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seed_reg  <= '0;
            second_seed_reg <= '0;
        end
        else
        begin
            first_seed_reg  <= first_seed_next;
            second_seed_reg <= second_seed_next;
        end
    end

    bsh_front #(
        .LEN_W (LEN_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .message_length (message_length),
        .first_word     (first_word),
        .last_word      (last_word),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (f_item),
        .q_len          (f_len)
    );

    bsh_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     ({f_len, f_item}),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    assign b_item = q_rdata[ITEM_W-1:0];
    assign b_len  = q_rdata[ENTRY_W-1:ITEM_W];

    bsh_back #(
        .LEN_W (LEN_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_item      (b_item),
        .q_len       (b_len),
        .q_pop       (q_pop),
        .first_seed  (first_seed_reg),
        .second_seed (second_seed_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the seeded 64-bit byte-stream hash unit.
// Depends on bsh_pkg and byte_stream_hash64_seeded_unit; keeps its own model of the hash.
// Directed corner messages, then random messages and noise under several seed settings.
module tb;

    localparam logic [63:0] MUL_P1 = 64'd11400714785074694791;
    localparam logic [63:0] MUL_P2 = 64'd14029467366897019727;
    localparam logic [63:0] MUL_P3 = 64'd1609587929392839161;
    localparam logic [63:0] MUL_P4 = 64'd9650029242287828579;
    localparam logic [63:0] MUL_P5 = 64'd2870177450012600261;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Indexes that map to no register; writes there must change nothing.
    localparam logic [bsh_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [bsh_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 300;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [63:0]                   data_word;
    logic [3:0]                    valid_bytes;
    logic [bsh_pkg::MSG_LEN_W-1:0] message_length;
    logic                          first_word;
    logic                          last_word;
    logic                          out_valid;
    logic                          out_ready;
    logic [63:0]                   hash_value;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bsh_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0]                   cfg_data;

    // Model state and copies of the seed registers.
    logic [63:0] chain_hash;
    bit          msg_open;
    logic [63:0] seed_first;
    logic [63:0] seed_second;

    logic [63:0] expected_hashes[$];
    bit          no_gaps;
    int          mismatches;
    int          words_sent;
    int          hashes_checked;
    int          seed_settings;
    int          quiet_cycles;

    byte_stream_hash64_seeded_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .message_length (message_length),
        .first_word     (first_word),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rot_left(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] mix_full_word(input logic [63:0] h, input logic [63:0] w);
        logic [63:0] k;
        k = w * MUL_P2;
        k = rot_left(k, 31) * MUL_P1;
        h = h ^ k;
        return rot_left(h, 27) * MUL_P1 + MUL_P4;
    endfunction

    function automatic logic [63:0] mix_tail_byte(input logic [63:0] h, input logic [7:0] b);
        h = h ^ ({56'd0, b} * MUL_P5);
        return rot_left(h, 11) * MUL_P1;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] h);
        h = h ^ (h >> 33);
        h = h * MUL_P2;
        h = h ^ (h >> 29);
        h = h * MUL_P3;
        return h ^ (h >> 32);
    endfunction

    // Advances the model by one word; returns 1 and the finished hash on a last word.
    function automatic bit absorb_word(input logic [63:0] w, input logic [3:0] nb_raw,
                                       input logic [31:0] len, input bit is_first,
                                       input bit is_last, output logic [63:0] digest);
        logic [63:0] h;
        int          nb;
        nb = (nb_raw > 4'd8) ? 8 : int'(nb_raw);
        if (is_first || !msg_open)
            h = MUL_P5 + {32'd0, len} * MUL_P3;
        else
            h = chain_hash;
        if (nb == 8)
            h = mix_full_word(h, w);
        else
            for (int i = 0; i < nb; i++)
                h = mix_tail_byte(h, w[8*i +: 8]);
        chain_hash = h;
        msg_open = !is_last;
        digest = avalanche(h) ^ seed_first ^ seed_second;
        return is_last;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Must be called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic [31:0] len,
                             input bit is_first, input bit is_last);
        int          gap;
        logic [63:0] digest;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_word      <= w;
        valid_bytes    <= nb;
        message_length <= len;
        first_word     <= is_first;
        last_word      <= is_last;
        do @(posedge clk); while (!in_ready);
        if (absorb_word(w, nb, len, is_first, is_last, digest))
            expected_hashes.push_back(digest);
        words_sent++;
    endtask

    // Holds input back until every pending hash has come out and the back end is quiet.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_seeds(input logic [63:0] a, input logic [63:0] b, input bit poke_spare);
        cfg_valid <= 1'b1;
        cfg_index <= bsh_pkg::REG_FIRST_SEED;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        seed_first = a;
        cfg_index <= bsh_pkg::REG_SECOND_SEED;
        cfg_data  <= b;
        do @(posedge clk); while (!cfg_ready);
        seed_second = b;
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE_LO;
            cfg_data  <= rand_word();
            do @(posedge clk); while (!cfg_ready);
            cfg_index <= REG_SPARE_HI;
            cfg_data  <= rand_word();
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        seed_settings++;
    endtask

    // A well-formed message: full words, then a tail word unless the last full word closes it.
    task automatic send_random_message();
        int          nfull;
        int          tail;
        int          total;
        logic [31:0] len;
        logic [3:0]  nb;
        nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        tail  = $urandom_range(0, 8);
        total = nfull * 8 + tail;
        case ($urandom_range(0, 9))
            0:       len = $urandom;
            1:       len = 32'hFFFF_FFFF;
            2:       len = 32'd0;
            default: len = total;
        endcase
        for (int i = 0; i < nfull; i++)
        begin
            nb = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            send_word(rand_word(), nb, (i == 0) ? len : $urandom, i == 0,
                      tail == 0 && i == nfull - 1);
        end
        if (tail > 0 || nfull == 0)
            send_word(rand_word(), 4'(tail), (nfull == 0) ? len : $urandom, nfull == 0, 1'b1);
    endtask

    task automatic send_noise_word();
        send_word(rand_word(), 4'($urandom_range(0, 15)), $urandom,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
    endtask

    task automatic test_directed_cases();
        // Empty message, then single-word messages at the extremes of data and length.
        send_word(64'd0, 4'd0, 32'd0, 1'b1, 1'b1);
        send_word(ALL_ONES, 4'd8, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(64'd0, 4'd8, 32'd8, 1'b1, 1'b1);
        send_word(ALL_ONES, 4'd7, 32'd7, 1'b1, 1'b1);
        // Byte counts above eight are taken as full words.
        send_word(64'h0123_4567_89AB_CDEF, 4'd9, 32'd24, 1'b1, 1'b0);
        send_word(64'hFEDC_BA98_7654_3210, 4'd12, 32'd24, 1'b0, 1'b0);
        send_word(ALL_ONES, 4'd15, 32'd24, 1'b0, 1'b1);
        // Full word followed by a seven-byte tail.
        send_word(rand_word(), 4'd8, 32'd15, 1'b1, 1'b0);
        send_word(rand_word(), 4'd7, 32'd0, 1'b0, 1'b1);
        // A short first word is mixed bytewise and the message stays open.
        send_word(rand_word(), 4'd3, 32'd12, 1'b1, 1'b0);
        send_word(rand_word(), 4'd8, 32'd12, 1'b0, 1'b0);
        send_word(rand_word(), 4'd1, 32'd12, 1'b0, 1'b1);
        // No first mark while idle: the word opens a message with its own length.
        send_word(rand_word(), 4'd8, 32'd13, 1'b0, 1'b0);
        send_word(rand_word(), 4'd5, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // A first mark inside an open message drops it and starts over.
        send_word(rand_word(), 4'd8, 32'd40, 1'b1, 1'b0);
        send_word(rand_word(), 4'd8, 32'd9, 1'b1, 1'b0);
        send_word(rand_word(), 4'd1, 32'd0, 1'b0, 1'b1);
        // Length that disagrees with the bytes sent.
        send_word(rand_word(), 4'd8, 32'd1000, 1'b1, 1'b0);
        send_word(rand_word(), 4'd8, 32'd1000, 1'b0, 1'b1);
        // Last word carrying no bytes after a full word.
        send_word(rand_word(), 4'd8, 32'd8, 1'b1, 1'b0);
        send_word(rand_word(), 4'd0, 32'd8, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target)
            send_random_message();
    endtask

    task automatic test_back_to_back(input int n_words);
        no_gaps = 1'b1;
        test_random_messages(n_words);
        no_gaps = 1'b0;
    endtask

    task automatic test_noise(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target)
            if ($urandom_range(0, 2) == 0)
                send_random_message();
            else
                send_noise_word();
    endtask

    task automatic check_hash(input logic [63:0] got);
        logic [63:0] want;
        if (expected_hashes.size() == 0)
        begin
            $error("hash_value beat with no hash pending: got %h", got);
            mismatches++;
        end
        else
        begin
            want = expected_hashes.pop_front();
            if (got !== want)
            begin
                $error("hash_value mismatch: expected %h, actual %h", want, got);
                mismatches++;
            end
            hashes_checked++;
        end
    endtask

    // Result side: a random stall before each beat, then take whatever arrives.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_hash(hash_value);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_word      <= 64'd0;
        valid_bytes    <= 4'd0;
        message_length <= '0;
        first_word     <= 1'b0;
        last_word      <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= bsh_pkg::REG_FIRST_SEED;
        cfg_data       <= 64'd0;
        chain_hash     = 64'd0;
        msg_open       = 1'b0;
        seed_first     = 64'd0;
        seed_second    = 64'd0;
        no_gaps        = 1'b0;
        mismatches     = 0;
        words_sent     = 0;
        hashes_checked = 0;
        seed_settings  = 1;
        quiet_cycles   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        finish_phase();
        load_seeds(ALL_ONES, 64'd0, 1'b1);
        test_random_messages(150);
        finish_phase();
        load_seeds(64'd0, ALL_ONES, 1'b0);
        test_random_messages(150);
        finish_phase();
        load_seeds(rand_word(), rand_word(), 1'b0);
        test_back_to_back(120);
        finish_phase();
        load_seeds(ALL_ONES, ALL_ONES, 1'b0);
        test_noise(150);
        test_random_messages(100);
        finish_phase();
        load_seeds(64'd0, 64'd0, 1'b0);
        test_random_messages(100);
        finish_phase();

        if (expected_hashes.size() != 0)
        begin
            $error("%0d hashes never came out", expected_hashes.size());
            mismatches++;
        end
        $display("Covered %0d words and %0d checked hashes under %0d seed settings,",
                 words_sent, hashes_checked, seed_settings);
        $display("including corner messages, back-to-back traffic and malformed words.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
